FILE: rtl/ptd_pkg.sv
package ptd_pkg;

  // Default table size and fixed field widths.
  localparam int TASK_SLOTS_DEF = 16;
  localparam int OP_W           = 3;
  localparam int SLOT_IN_W      = 8;
  localparam int TIME_W         = 8;
  localparam int KIND_W         = 2;
  localparam int TSLOT_W        = 6;
  localparam int STATUS_W       = 2;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
  localparam logic [OP_W-1:0] OP_CREATE  = 3'd1;
  localparam logic [OP_W-1:0] OP_DELETE  = 3'd2;
  localparam logic [OP_W-1:0] OP_SUSPEND = 3'd3;
  localparam logic [OP_W-1:0] OP_RESUME  = 3'd4;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_STATUS   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DISPATCH = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DONE     = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_RANGE    = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_OCCUPIED = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd3;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EVAL,
    S_DONE
  } state_t;

  // One entry of the timing memory.
  typedef struct packed {
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] cd;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic op_exec;
    logic tick_start;
    logic rd_en;
    logic idx_inc;
    logic commit;
    logic emit_done;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic active;
    logic last_slot;
    logic fire;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/ptd_ctrl.sv
module ptd_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic [ptd_pkg::OP_W-1:0] op,
  input  ptd_pkg::sts_t          sts,
  output logic                   in_stall,
  output ptd_pkg::cmd_t          cmd
);
  import ptd_pkg::*;

  state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall = !sts.out_free;
        if (in_valid && sts.out_free) begin
          if (op == OP_TICK) begin
            cmd.tick_start = 1'b1;
            state_next     = S_SCAN;
          end else begin
            cmd.op_exec = 1'b1;
          end
        end
      end
      S_SCAN: begin
        if (sts.active) begin
          cmd.rd_en  = 1'b1;
          state_next = S_EVAL;
        end else if (sts.last_slot) begin
          state_next = S_DONE;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_EVAL: begin
        // A dispatch waits for room in the output register.
        if (!sts.fire || sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = sts.last_slot ? S_DONE : S_SCAN;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.emit_done = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/ptd_datapath.sv
module ptd_datapath #(
  parameter int TASK_SLOTS = ptd_pkg::TASK_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ptd_pkg::cmd_t                 cmd,
  input  logic [ptd_pkg::OP_W-1:0]      op,
  input  logic [ptd_pkg::SLOT_IN_W-1:0] slot,
  input  logic [ptd_pkg::TIME_W-1:0]    period,
  input  logic [ptd_pkg::TIME_W-1:0]    first_delay,
  input  logic                          out_stall,
  output ptd_pkg::sts_t                 sts,
  output logic                          out_valid,
  output logic [ptd_pkg::KIND_W-1:0]    kind,
  output logic [ptd_pkg::TSLOT_W-1:0]   task_slot,
  output logic [ptd_pkg::STATUS_W-1:0]  status,
  output logic                          last
);
  import ptd_pkg::*;

  localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

  logic [TASK_SLOTS-1:0] used;
  logic [TASK_SLOTS-1:0] ready;
  entry_t                mem [TASK_SLOTS];
  entry_t                rd_data;
  logic [IDX_W-1:0]      idx;

  logic                  in_range;
  logic [IDX_W-1:0]      op_idx;
  logic [STATUS_W-1:0]   op_status;
  logic                  we;
  logic [IDX_W-1:0]      wr_addr;
  entry_t                wr_data;
  logic [TIME_W-1:0]     cd_dec;
  logic                  out_free;
  logic                  load_out;

  // Decode of a table operation.
  assign in_range = slot < SLOT_IN_W'(TASK_SLOTS);
  assign op_idx   = slot[IDX_W-1:0];

  always_comb begin
    op_status = STAT_OK;
    case (op)
      OP_CREATE: begin
        if (!in_range) begin
          op_status = STAT_RANGE;
        end else if (used[op_idx]) begin
          op_status = STAT_OCCUPIED;
        end
      end
      OP_DELETE, OP_SUSPEND, OP_RESUME: begin
        if (!in_range) begin
          op_status = STAT_RANGE;
        end else if (!used[op_idx]) begin
          op_status = STAT_EMPTY;
        end
      end
      default: begin
        op_status = STAT_OK;
      end
    endcase
  end

  // Used and ready flags; an unused slot never reads the memory.
  always_ff @(posedge clk) begin
    if (rst) begin
      used  <= '0;
      ready <= '0;
    end else if (cmd.op_exec && op_status == STAT_OK) begin
      case (op)
        OP_CREATE: begin
          used[op_idx]  <= 1'b1;
          ready[op_idx] <= 1'b1;
        end
        OP_DELETE: begin
          used[op_idx]  <= 1'b0;
          ready[op_idx] <= 1'b0;
        end
        OP_SUSPEND: begin
          ready[op_idx] <= 1'b0;
        end
        OP_RESUME: begin
          ready[op_idx] <= 1'b1;
        end
        default: begin
          used <= used;
        end
      endcase
    end
  end

  // Countdown step of the slot under evaluation.
  assign cd_dec = (rd_data.cd == '0) ? '0 : rd_data.cd - 1'b1;

  // Single write port: create loads an entry, a tick step updates one.
  always_comb begin
    we      = 1'b0;
    wr_addr = idx;
    wr_data = rd_data;
    if (cmd.op_exec) begin
      we             = (op == OP_CREATE) && (op_status == STAT_OK);
      wr_addr        = op_idx;
      wr_data.period = period;
      wr_data.cd     = first_delay;
    end else if (cmd.commit) begin
      we             = 1'b1;
      wr_data.period = rd_data.period;
      wr_data.cd     = (cd_dec == '0) ? rd_data.period : cd_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data <= mem[idx];
    end
  end

  // Slot walk counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.tick_start) begin
      idx <= '0;
    end else if (cmd.idx_inc || cmd.commit) begin
      idx <= idx + 1'b1;
    end
  end

  // Output register; it frees up in the same cycle its beat is taken.
  assign out_free = !out_valid || !out_stall;
  assign load_out = cmd.op_exec || cmd.emit_done || (cmd.commit && cd_dec == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op_exec) begin
      kind      <= KIND_STATUS;
      task_slot <= '0;
      status    <= op_status;
      last      <= 1'b1;
    end else if (cmd.emit_done) begin
      kind      <= KIND_DONE;
      task_slot <= '0;
      status    <= STAT_OK;
      last      <= 1'b1;
    end else if (cmd.commit && cd_dec == '0) begin
      kind      <= KIND_DISPATCH;
      task_slot <= TSLOT_W'(idx);
      status    <= STAT_OK;
      last      <= 1'b0;
    end
  end

  // Status toward the controller.
  always_comb begin
    sts.active    = used[idx] && ready[idx];
    sts.last_slot = idx == IDX_W'(TASK_SLOTS - 1);
    sts.fire      = cd_dec == '0;
    sts.out_free  = out_free;
  end

endmodule

FILE: rtl/periodic_task_dispatcher.sv
// Channel   Handshake             Payload
// input     in_valid / in_stall   op, slot, period, first_delay
// output    out_valid / out_stall kind, task_slot, status, last
//
// A create, delete, suspend or resume op gives one status beat. During a tick the
// slot walk visits every slot in turn: an idle slot is passed over, and an active
// (used and ready) slot is read and then updated in the countdown memory, which
// has a single write port; a done beat then closes the tick.
// Reset clears the used and ready flags at once; no clearing pass is needed.
// A stalled output holds its beat; the walk waits only when it has a beat to emit.
module periodic_task_dispatcher #(
  parameter int TASK_SLOTS = ptd_pkg::TASK_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ptd_pkg::OP_W-1:0]      op,
  input  logic [ptd_pkg::SLOT_IN_W-1:0] slot,
  input  logic [ptd_pkg::TIME_W-1:0]    period,
  input  logic [ptd_pkg::TIME_W-1:0]    first_delay,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ptd_pkg::KIND_W-1:0]    kind,
  output logic [ptd_pkg::TSLOT_W-1:0]   task_slot,
  output logic [ptd_pkg::STATUS_W-1:0]  status,
  output logic                          last
);
  import ptd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  ptd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .op       (op),
    .sts      (sts),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  // Task table and output register.
  ptd_datapath #(
    .TASK_SLOTS (TASK_SLOTS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .op          (op),
    .slot        (slot),
    .period      (period),
    .first_delay (first_delay),
    .out_stall   (out_stall),
    .sts         (sts),
    .out_valid   (out_valid),
    .kind        (kind),
    .task_slot   (task_slot),
    .status      (status),
    .last        (last)
  );

endmodule

FILE: rtl/ptd_checker.sv
module ptd_checker #(
  parameter int TASK_SLOTS = ptd_pkg::TASK_SLOTS_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic [ptd_pkg::OP_W-1:0]      op,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [ptd_pkg::KIND_W-1:0]    kind,
  input logic [ptd_pkg::TSLOT_W-1:0]   task_slot,
  input logic [ptd_pkg::STATUS_W-1:0]  status,
  input logic                          last
);
  import ptd_pkg::*;

  // A table op answers with its status beat in the next cycle.
  a_op_answer: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && op != OP_TICK |=> out_valid && kind == KIND_STATUS)
    else $error("op status beat missing");

  // Dispatch beats never close an input and name a real slot.
  a_dispatch: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_DISPATCH |-> !last && task_slot < TSLOT_W'(TASK_SLOTS))
    else $error("bad dispatch beat");

  // Done beats close the tick and carry no slot or status.
  a_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_DONE |-> last && task_slot == '0 && status == STAT_OK)
    else $error("bad done beat");

  // Status beats close their op.
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_STATUS |-> last && task_slot == '0)
    else $error("bad status beat");

  // A stalled output beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(task_slot)
      && $stable(status) && $stable(last))
    else $error("stalled output beat changed");

endmodule

bind periodic_task_dispatcher ptd_checker #(
  .TASK_SLOTS (TASK_SLOTS)
) u_ptd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .op        (op),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .kind      (kind),
  .task_slot (task_slot),
  .status    (status),
  .last      (last)
);

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps

import ptd_pkg::*;

// Tracks the task table on the side and holds the beats that the block still owes.
class dispatch_tracker;

  typedef struct {
    logic [KIND_W-1:0]   kind;
    logic [TSLOT_W-1:0]  task_slot;
    logic [STATUS_W-1:0] status;
    logic                last;
  } beat_t;

  bit                used [TASK_SLOTS_DEF];
  bit                ready [TASK_SLOTS_DEF];
  logic [TIME_W-1:0] reload [TASK_SLOTS_DEF];
  logic [TIME_W-1:0] count [TASK_SLOTS_DEF];
  beat_t             owed_beats [$];
  int unsigned       errors;

  function new();
    foreach (used[i]) begin
      used[i] = 1'b0;
      ready[i] = 1'b0;
      reload[i] = '0;
      count[i] = '0;
    end
    errors = 0;
  endfunction

  function void owe(logic [KIND_W-1:0] k, logic [TSLOT_W-1:0] ts,
                    logic [STATUS_W-1:0] st, logic lst);
    beat_t b;
    b.kind = k;
    b.task_slot = ts;
    b.status = st;
    b.last = lst;
    owed_beats.push_back(b);
  endfunction

  // Applies one accepted request to the table and queues the beats it causes.
  function void accept_request(logic [OP_W-1:0] req_op, logic [SLOT_IN_W-1:0] req_slot,
                               logic [TIME_W-1:0] req_period, logic [TIME_W-1:0] req_delay);
    logic [STATUS_W-1:0] st;
    st = STAT_OK;
    if (req_op == OP_TICK) begin
      // The walk goes up from slot 0, so dispatches come out in ascending slot order.
      for (int i = 0; i < TASK_SLOTS_DEF; i++) begin
        if (used[i] && ready[i]) begin
          if (count[i] != '0) count[i] = count[i] - 1'b1;
          if (count[i] == '0) begin
            owe(KIND_DISPATCH, TSLOT_W'(i), STAT_OK, 1'b0);
            count[i] = reload[i];
          end
        end
      end
      owe(KIND_DONE, '0, STAT_OK, 1'b1);
    end else begin
      // Codes above resume fall through as a no-op with an ok status.
      if (req_op <= OP_RESUME) begin
        if (req_slot >= TASK_SLOTS_DEF) begin
          st = STAT_RANGE;
        end else if (req_op == OP_CREATE) begin
          if (used[req_slot]) begin
            st = STAT_OCCUPIED;
          end else begin
            used[req_slot] = 1'b1;
            ready[req_slot] = 1'b1;
            reload[req_slot] = req_period;
            count[req_slot] = req_delay;
          end
        end else if (!used[req_slot]) begin
          st = STAT_EMPTY;
        end else if (req_op == OP_DELETE) begin
          used[req_slot] = 1'b0;
          ready[req_slot] = 1'b0;
          reload[req_slot] = '0;
          count[req_slot] = '0;
        end else if (req_op == OP_SUSPEND) begin
          ready[req_slot] = 1'b0;
        end else begin
          ready[req_slot] = 1'b1;
        end
      end
      owe(KIND_STATUS, '0, st, 1'b1);
    end
  endfunction

  // Compares one output beat with the oldest owed beat.
  function void check_beat(logic [KIND_W-1:0] k, logic [TSLOT_W-1:0] ts,
                           logic [STATUS_W-1:0] st, logic lst);
    beat_t b;
    if (owed_beats.size() == 0) begin
      $error("unexpected beat: kind %0d task_slot %0d status %0d last %0d", k, ts, st, lst);
      errors++;
    end else begin
      b = owed_beats.pop_front();
      if (k !== b.kind) begin
        $error("kind: expected %0d, actual %0d", b.kind, k);
        errors++;
      end
      if (ts !== b.task_slot) begin
        $error("task_slot: expected %0d, actual %0d", b.task_slot, ts);
        errors++;
      end
      if (st !== b.status) begin
        $error("status: expected %0d, actual %0d", b.status, st);
        errors++;
      end
      if (lst !== b.last) begin
        $error("last: expected %0d, actual %0d", b.last, lst);
        errors++;
      end
    end
  endfunction

  function int unsigned owed();
    return owed_beats.size();
  endfunction

endclass

module tb_top;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RX_HOLD        = 300;
  localparam int TAIL_CYCLES    = 60;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic [OP_W-1:0]      op;
  logic [SLOT_IN_W-1:0] slot;
  logic [TIME_W-1:0]    period;
  logic [TIME_W-1:0]    first_delay;
  logic                 out_valid;
  logic                 out_stall;
  logic [KIND_W-1:0]    kind;
  logic [TSLOT_W-1:0]   task_slot;
  logic [STATUS_W-1:0]  status;
  logic                 last;

  int unsigned     tx_idle = 0;
  int unsigned     rx_idle = 0;
  bit              hold_req = 1'b0;
  int unsigned     quiet_cycles = 0;
  dispatch_tracker tracker;

  always #2 clk = ~clk;

  periodic_task_dispatcher #(
    .TASK_SLOTS(TASK_SLOTS_DEF)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .op(op),
    .slot(slot),
    .period(period),
    .first_delay(first_delay),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .kind(kind),
    .task_slot(task_slot),
    .status(status),
    .last(last)
  );

  // Offers one request beat after a random gap and waits until it is taken.
  task automatic send_request(input logic [OP_W-1:0] req_op, input logic [SLOT_IN_W-1:0] req_slot,
                              input logic [TIME_W-1:0] req_period,
                              input logic [TIME_W-1:0] req_delay);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    op <= req_op;
    slot <= req_slot;
    period <= req_period;
    first_delay <= req_delay;
    do @(posedge clk); while (in_stall);
    tracker.accept_request(req_op, req_slot, req_period, req_delay);
  endtask

  // Mostly in-range slots and short periods so that ticks dispatch often.
  task automatic send_random_request();
    int unsigned          pick;
    logic [OP_W-1:0]      r_op;
    logic [SLOT_IN_W-1:0] r_slot;
    logic [TIME_W-1:0]    r_period;
    logic [TIME_W-1:0]    r_delay;
    pick = $urandom_range(99);
    if (pick < 35) r_op = OP_TICK;
    else if (pick < 55) r_op = OP_CREATE;
    else if (pick < 70) r_op = OP_DELETE;
    else if (pick < 80) r_op = OP_SUSPEND;
    else if (pick < 92) r_op = OP_RESUME;
    else r_op = OP_W'($urandom_range(7, 5));
    if ($urandom_range(99) < 85) r_slot = SLOT_IN_W'($urandom_range(TASK_SLOTS_DEF - 1));
    else r_slot = SLOT_IN_W'($urandom_range(255));
    if ($urandom_range(99) < 80) r_period = TIME_W'($urandom_range(7));
    else r_period = TIME_W'($urandom_range(255));
    if ($urandom_range(99) < 80) r_delay = TIME_W'($urandom_range(7));
    else r_delay = TIME_W'($urandom_range(255));
    send_request(r_op, r_slot, r_period, r_delay);
  endtask

  // Receiver side: random stalls, or one long hold-off when requested.
  initial begin : rx_drive
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        for (int n = 1; n < RX_HOLD; n++) @(negedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < rx_idle);
      end
    end
  end

  // Every accepted output beat is checked against the tracker.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) tracker.check_beat(kind, task_slot, status, last);
  end

  // Ends the run if no beat moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : main_seq
    tracker = new();
    rst = 1'b1;
    in_valid = 1'b0;
    op = OP_TICK;
    slot = '0;
    period = '0;
    first_delay = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part: status codes, field extremes and the timing corner cases.
    send_request(OP_TICK, 8'd0, 8'd0, 8'd0);
    send_request(OP_CREATE, 8'd0, 8'd0, 8'd0);
    send_request(OP_CREATE, 8'd15, 8'd255, 8'd255);
    send_request(OP_CREATE, 8'd0, 8'd3, 8'd3);
    send_request(OP_CREATE, 8'd16, 8'd1, 8'd1);
    send_request(OP_CREATE, 8'd255, 8'd255, 8'd255);
    send_request(OP_DELETE, 8'd3, 8'd0, 8'd0);
    send_request(OP_SUSPEND, 8'd3, 8'd0, 8'd0);
    send_request(OP_RESUME, 8'd3, 8'd0, 8'd0);
    send_request(OP_SUSPEND, 8'd200, 8'd0, 8'd0);
    send_request(OP_DELETE, 8'd128, 8'd0, 8'd0);
    send_request(OP_RESUME, 8'd16, 8'd0, 8'd0);
    send_request(OP_CREATE, 8'd5, 8'd2, 8'd1);
    send_request(OP_TICK, 8'd255, 8'd255, 8'd255);
    send_request(OP_TICK, 8'd0, 8'd0, 8'd0);
    send_request(OP_SUSPEND, 8'd0, 8'd0, 8'd0);
    send_request(OP_SUSPEND, 8'd0, 8'd0, 8'd0);
    send_request(OP_TICK, 8'd0, 8'd0, 8'd0);
    send_request(OP_RESUME, 8'd0, 8'd0, 8'd0);
    send_request(OP_RESUME, 8'd0, 8'd0, 8'd0);
    send_request(3'd5, 8'd255, 8'd255, 8'd255);
    send_request(3'd6, 8'd7, 8'd0, 8'd0);
    send_request(3'd7, 8'd0, 8'd170, 8'd85);
    send_request(OP_DELETE, 8'd0, 8'd0, 8'd0);
    send_request(OP_DELETE, 8'd15, 8'd0, 8'd0);
    send_request(OP_TICK, 8'd0, 8'd0, 8'd0);

    // Random part in three idling phases; the last one starts with a long hold-off.
    tx_idle = 30;
    rx_idle = 55;
    for (int k = 0; k < 120; k++) send_random_request();
    tx_idle = 55;
    rx_idle = 30;
    for (int k = 0; k < 120; k++) send_random_request();
    tx_idle = 0;
    rx_idle = 0;
    hold_req = 1'b1;
    for (int k = 0; k < 115; k++) send_random_request();
    @(negedge clk);
    in_valid <= 1'b0;

    // Drain the owed beats, then watch a while for anything extra.
    while (tracker.owed() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
